FILE: rtl/ultrasonic_ping_echo_ranger_macros.svh
// Assertion macros for the ultrasonic ping and echo ranger.
// Included by the top level; the including scope provides clk and rst_n.
`ifndef ULTRASONIC_PING_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_PING_ECHO_RANGER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define UPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ranger check failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define UPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ranger check failed in the next cycle");

`endif

FILE: rtl/uper_pkg.sv
// Shared types and constants of the ultrasonic ping and echo ranger.
// No dependencies; used by every other file of the block but uper_echo_if and the macros.
package uper_pkg;

    localparam int TIME_W      = 16;
    localparam int PRESCALE_W  = 10;
    localparam int TRIG_W      = 6;
    localparam int FRAC_W      = 4;
    localparam int DIVIDEND_W  = TIME_W + FRAC_W;
    localparam int DIST_W      = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH = 2'd1;

    localparam logic [TIME_W-1:0] PING_INTERVAL_RESET = 16'd60;
    localparam logic [TRIG_W-1:0] TRIGGER_WIDTH_RESET = 6'd30;
    localparam logic [TIME_W-1:0] MS_SATURATE         = 16'hFFFF;

    typedef struct packed {
        logic              trigger;
        logic              fresh;
        logic [TIME_W-1:0] width;
    } meas_t;

endpackage

FILE: rtl/uper_echo_if.sv
// Input channel of the ranger: one sampled echo level per item.
// Depends on nothing.
interface uper_echo_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink (input valid, input echo_level, output ready);
endinterface

FILE: rtl/uper_result_if.sv
// Result channel of the ranger: trigger level, reading flag and distance.
// Depends on uper_pkg for the distance width.
interface uper_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        new_reading;
    logic [uper_pkg::DIST_W-1:0] distance_q4;

    modport source (output valid, output trigger_level, output new_reading,
                    output distance_q4, input ready);
    modport sink (input valid, input trigger_level, input new_reading,
                  input distance_q4, output ready);
endinterface

FILE: rtl/ultrasonic_ping_echo_ranger.sv
// Ultrasonic ping and echo ranger: one item per microsecond tick, one result per item.
// From the edge that accepts an item to a valid result, the item passes the input register,
// the counter stage and the result register. Throughput is one item per cycle while result.ready holds.
// Reset clears all counters, the held distance and the item valid flags, and sets the ping
// interval to 60 ms and the trigger width to 30 ticks.
// Depends on uper_pkg, uper_echo_if, uper_result_if, uper_ctrl, uper_scale and the macros.
`include "ultrasonic_ping_echo_ranger_macros.svh"

module ultrasonic_ping_echo_ranger #(
    parameter int TICKS_PER_MS = 1000,
    parameter int CM_DIVISOR   = 58
) (
    input  logic                              clk,
    input  logic                              rst_n,
    uper_echo_if.sink                         echo,
    uper_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [uper_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [uper_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [uper_pkg::TIME_W-1:0] ping_interval_reg;
    logic [uper_pkg::TRIG_W-1:0] trigger_width_reg;
    uper_pkg::meas_t             mid_item;
    logic                        mid_valid;
    logic                        mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_interval_reg <= uper_pkg::PING_INTERVAL_RESET;
            trigger_width_reg <= uper_pkg::TRIGGER_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uper_pkg::CFG_PING_INTERVAL:
                begin
                    ping_interval_reg <= cfg_data[uper_pkg::TIME_W-1:0];
                end
                uper_pkg::CFG_TRIGGER_WIDTH:
                begin
                    trigger_width_reg <= cfg_data[uper_pkg::TRIG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    uper_ctrl #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .echo          (echo),
        .ping_interval (ping_interval_reg),
        .trigger_width (trigger_width_reg),
        .mid_item      (mid_item),
        .mid_valid     (mid_valid),
        .mid_ready     (mid_ready)
    );

    uper_scale #(
        .CM_DIVISOR (CM_DIVISOR)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_item),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .result    (result)
    );

    `UPR_ASSERT_NXT(a_mid_to_result, mid_valid && mid_ready, result.valid)
    `UPR_ASSERT_NXT(a_mid_holds, mid_valid && !mid_ready, mid_valid && $stable(mid_item))
    `UPR_ASSERT_IMP(a_empty_output_takes, !result.valid, mid_ready)

endmodule

FILE: rtl/uper_ctrl.sv
// Input register, tick counters, edge detection and ping timing of the ranger.
// Depends on uper_pkg and uper_echo_if; feeds uper_scale with one item a cycle while mid_ready is high.
module uper_ctrl #(
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    uper_echo_if.sink                     echo,
    input  logic [uper_pkg::TIME_W-1:0]   ping_interval,
    input  logic [uper_pkg::TRIG_W-1:0]   trigger_width,
    output uper_pkg::meas_t               mid_item,
    output logic                          mid_valid,
    input  logic                          mid_ready
);

    localparam logic [uper_pkg::PRESCALE_W:0] TICKS = (uper_pkg::PRESCALE_W + 1)'(TICKS_PER_MS);

    logic                            in_valid_reg;
    logic                            in_echo_reg;
    logic                            mid_valid_reg;
    uper_pkg::meas_t                 mid_item_reg;
    uper_pkg::meas_t                 mid_item_next;

    logic [uper_pkg::TIME_W-1:0]     time_reg;
    logic [uper_pkg::PRESCALE_W-1:0] prescale_reg;
    logic [uper_pkg::PRESCALE_W-1:0] prescale_next;
    logic [uper_pkg::TIME_W-1:0]     ms_reg;
    logic [uper_pkg::TIME_W-1:0]     ms_next;
    logic [uper_pkg::TIME_W-1:0]     start_reg;
    logic [uper_pkg::TIME_W-1:0]     start_next;
    logic [uper_pkg::TRIG_W-1:0]     remain_reg;
    logic [uper_pkg::TRIG_W-1:0]     remain_next;
    logic [uper_pkg::TRIG_W-1:0]     remain_loaded;
    logic                            prev_reg;

    logic                            in_take;
    logic                            step;
    logic                            rising;
    logic                            falling;
    logic                            wrap;
    logic                            ping;
    logic [uper_pkg::TIME_W-1:0]     width;
    logic [uper_pkg::TIME_W-1:0]     ms_tick;

    assign step       = in_valid_reg && (!mid_valid_reg || mid_ready);
    assign echo.ready = !in_valid_reg || step;
    assign in_take    = echo.valid && echo.ready;
    assign mid_valid  = mid_valid_reg;
    assign mid_item   = mid_item_reg;

    always_comb
    begin
        rising  = in_echo_reg && !prev_reg;
        falling = !in_echo_reg && prev_reg;
        width   = time_reg - start_reg;

        start_next = rising ? time_reg : start_reg;

        wrap = ({1'b0, prescale_reg} + 1'b1) >= TICKS;
        prescale_next = wrap ? '0 : prescale_reg + 1'b1;

        ms_tick = (wrap && (ms_reg != uper_pkg::MS_SATURATE)) ? ms_reg + 1'b1 : ms_reg;
        if (in_echo_reg)
        begin
            ms_tick = '0;
        end

        ping          = ms_tick >= ping_interval;
        ms_next       = ping ? '0 : ms_tick;
        remain_loaded = ping ? trigger_width : remain_reg;
        if (ping)
        begin
            start_next = '0;
        end

        remain_next = (remain_loaded != '0) ? remain_loaded - 1'b1 : remain_loaded;

        mid_item_next.trigger = remain_loaded != '0;
        mid_item_next.fresh   = falling && (width != '0);
        mid_item_next.width   = width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            time_reg      <= '0;
            prescale_reg  <= '0;
            ms_reg        <= '0;
            start_reg     <= '0;
            remain_reg    <= '0;
            prev_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !step);
            mid_valid_reg <= step || (mid_valid_reg && !mid_ready);
            if (step)
            begin
                time_reg     <= time_reg + 1'b1;
                prescale_reg <= prescale_next;
                ms_reg       <= ms_next;
                start_reg    <= start_next;
                remain_reg   <= remain_next;
                prev_reg     <= in_echo_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_echo_reg <= echo.echo_level;
        end
        if (step)
        begin
            mid_item_reg <= mid_item_next;
        end
    end

endmodule

FILE: rtl/uper_scale.sv
// Distance conversion and result register of the ranger.
// Depends on uper_pkg and uper_result_if; divides by a reciprocal multiply.
module uper_scale #(
    parameter int CM_DIVISOR = 58
) (
    input  logic            clk,
    input  logic            rst_n,
    input  uper_pkg::meas_t mid_item,
    input  logic            mid_valid,
    output logic            mid_ready,
    uper_result_if.source   result
);

    localparam int DIV_SHIFT = uper_pkg::DIVIDEND_W + $clog2(CM_DIVISOR);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = uper_pkg::DIVIDEND_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CM_DIVISOR) - 64'd1) / 64'(CM_DIVISOR));

    logic                          valid_reg;
    logic                          trigger_reg;
    logic                          fresh_reg;
    logic [uper_pkg::DIST_W-1:0]   dist_reg;
    logic                          load;
    logic [uper_pkg::DIVIDEND_W-1:0] dividend;
    logic [PROD_W-1:0]             product;
    logic [uper_pkg::DIST_W-1:0]   quotient;

    assign mid_ready = !valid_reg || result.ready;
    assign load      = mid_valid && mid_ready;

    assign dividend = {mid_item.width, {uper_pkg::FRAC_W{1'b0}}};
    assign product  = PROD_W'(dividend) * PROD_W'(RECIP);
    assign quotient = product[DIV_SHIFT +: uper_pkg::DIST_W];

    assign result.valid         = valid_reg;
    assign result.trigger_level = trigger_reg;
    assign result.new_reading   = fresh_reg;
    assign result.distance_q4   = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            valid_reg <= load || (valid_reg && !result.ready);
            if (load && mid_item.fresh)
            begin
                dist_reg <= quotient;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            trigger_reg <= mid_item.trigger;
            fresh_reg   <= mid_item.fresh;
        end
    end

endmodule

FILE: tb/sv/tb_ultrasonic_ping_echo_ranger.sv
// Self-checking testbench of the ultrasonic ping and echo ranger.
// Echo items are driven from a backlog, each result is predicted by a behavioural copy of the
// ranger and compared field by field. Depends on uper_pkg, uper_echo_if and uper_result_if.
module tb_ultrasonic_ping_echo_ranger;

    localparam int TICKS_PER_MS  = 1000;
    localparam int CM_DIVISOR    = 58;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 100;
    localparam int TOTAL_ITEMS   = 600;

    localparam int TIME_W      = uper_pkg::TIME_W;
    localparam int PRESCALE_W  = uper_pkg::PRESCALE_W;
    localparam int TRIG_W      = uper_pkg::TRIG_W;
    localparam int FRAC_W      = uper_pkg::FRAC_W;
    localparam int DIVIDEND_W  = uper_pkg::DIVIDEND_W;
    localparam int DIST_W      = uper_pkg::DIST_W;
    localparam int CFG_INDEX_W = uper_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = uper_pkg::CFG_DATA_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic              trigger;
        logic              fresh;
        logic [DIST_W-1:0] distance;
    } reading_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   echo_valid = 1'b0;
    logic                   echo_bit = 1'b0;
    logic                   result_ready = 1'b0;
    logic                   echo_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fed = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    logic     echo_backlog[$];
    reading_t reading_due[$];
    reading_t want;

    logic [TIME_W-1:0]     ping_ms = uper_pkg::PING_INTERVAL_RESET;
    logic [TRIG_W-1:0]     trig_us = uper_pkg::TRIGGER_WIDTH_RESET;
    logic [TIME_W-1:0]     us_count = '0;
    logic [PRESCALE_W-1:0] prescale = '0;
    logic [TIME_W-1:0]     holdoff_ms = '0;
    logic [TIME_W-1:0]     echo_start = '0;
    logic [TRIG_W-1:0]     trig_left = '0;
    logic                  echo_was_high = 1'b0;
    logic [DIST_W-1:0]     distance_held = '0;

    uper_echo_if echo_ch ();
    uper_result_if result_ch ();

    assign echo_ch.valid      = echo_valid;
    assign echo_ch.echo_level = echo_bit;
    assign result_ch.ready    = result_ready;

    ultrasonic_ping_echo_ranger #(
        .TICKS_PER_MS(TICKS_PER_MS),
        .CM_DIVISOR(CM_DIVISOR)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .echo(echo_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void step_ranger(input logic echo_in);
        logic [TIME_W-1:0]     width;
        logic [DIVIDEND_W-1:0] scaled;
        reading_t              due;
        due = '0;
        if (echo_in && !echo_was_high)
        begin
            echo_start = us_count;
        end
        else if (!echo_in && echo_was_high)
        begin
            width = us_count - echo_start;
            if (width != '0)
            begin
                scaled = {width, {FRAC_W{1'b0}}};
                distance_held = DIST_W'(scaled / DIVIDEND_W'(CM_DIVISOR));
                due.fresh = 1'b1;
            end
        end
        echo_was_high = echo_in;
        if (int'(prescale) + 1 >= TICKS_PER_MS)
        begin
            prescale = '0;
            if (holdoff_ms != uper_pkg::MS_SATURATE)
                holdoff_ms = holdoff_ms + 1'b1;
        end
        else
        begin
            prescale = prescale + 1'b1;
        end
        if (echo_in)
            holdoff_ms = '0;
        if (holdoff_ms >= ping_ms)
        begin
            echo_start = '0;
            holdoff_ms = '0;
            trig_left = trig_us;
        end
        if (trig_left != '0)
        begin
            due.trigger = 1'b1;
            trig_left = trig_left - 1'b1;
        end
        us_count = us_count + 1'b1;
        due.distance = distance_held;
        reading_due.push_back(due);
    endfunction

    function automatic void check_field(input string what, input logic [DIST_W-1:0] expected,
                                        input logic [DIST_W-1:0] actual);
        if (actual !== expected)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %0d actual %0d", $time, what, expected, actual);
        end
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!echo_valid || echo_taken)
            begin
                if (echo_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    echo_valid <= 1'b1;
                    echo_bit <= echo_backlog.pop_front();
                end
                else
                begin
                    echo_valid <= 1'b0;
                end
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            echo_taken <= echo_valid && echo_ch.ready;
            if (echo_valid && echo_ch.ready)
                step_ranger(echo_bit);
            if (result_ch.valid && result_ready)
            begin
                if (reading_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result expected none actual %0b %0b %0d",
                                 $time, result_ch.trigger_level, result_ch.new_reading,
                                 result_ch.distance_q4);
                end
                else
                begin
                    want = reading_due.pop_front();
                    check_field("trigger_level", DIST_W'(want.trigger),
                                DIST_W'(result_ch.trigger_level));
                    check_field("new_reading", DIST_W'(want.fresh), DIST_W'(result_ch.new_reading));
                    check_field("distance_q4", want.distance, result_ch.distance_q4);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((echo_valid && echo_ch.ready) || (result_ch.valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb_ultrasonic_ping_echo_ranger NOT OK");
            $finish;
        end
    end

    task automatic feed_bit(input logic level);
        echo_backlog.push_back(level);
        fed++;
    endtask

    task automatic feed_pattern(input string pattern);
        for (int i = 0; i < pattern.len(); i++)
            feed_bit(pattern[i] == "1");
    endtask

    // Echo pulses with random gaps and widths and at times random bits, cut off at the requested item count.
    task automatic feed_pulses(input int count);
        int stop_at;
        int low_len;
        int high_len;
        stop_at = fed + count;
        while (fed < stop_at)
        begin
            if ($urandom_range(4) == 0)
                low_len = $urandom_range(40, 13);
            else
                low_len = $urandom_range(12, 1);
            case ($urandom_range(9))
                0: high_len = $urandom_range(60, 20);
                1: high_len = 1;
                default: high_len = $urandom_range(15, 2);
            endcase
            for (int i = 0; i < low_len && fed < stop_at; i++)
                feed_bit(1'b0);
            for (int i = 0; i < high_len && fed < stop_at; i++)
                feed_bit(1'b1);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(8, 1))
                    if (fed < stop_at)
                        feed_bit(1'($urandom));
        end
    endtask

    task automatic drain();
        while (echo_backlog.size() != 0 || echo_valid || reading_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            uper_pkg::CFG_PING_INTERVAL: ping_ms = value;
            uper_pkg::CFG_TRIGGER_WIDTH: trig_us = value[TRIG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        feed_pattern("010111100010");
        feed_pulses(120);
        drain();

        // A zero interval pings on every tick, so widths are measured from the cleared start.
        write_reg(CFG_UNUSED_2, 16'($urandom));
        write_reg(CFG_UNUSED_3, 16'($urandom));
        write_reg(uper_pkg::CFG_PING_INTERVAL, '0);
        write_reg(uper_pkg::CFG_TRIGGER_WIDTH, {10'($urandom), 6'h00});
        set_idling(45, 0);
        feed_pattern("110010");
        feed_pulses(100);
        drain();

        write_reg(uper_pkg::CFG_TRIGGER_WIDTH, {10'($urandom), 6'h3F});
        set_idling(0, 45);
        feed_pattern("0010");
        feed_pulses(100);
        drain();

        // Pings stop here, so the pulse loaded last runs down.
        write_reg(uper_pkg::CFG_PING_INTERVAL, 16'd1);
        write_reg(uper_pkg::CFG_TRIGGER_WIDTH, 16'($urandom_range(63, 1)));
        set_idling(21, 21);
        feed_pulses(100);
        drain();

        write_reg(uper_pkg::CFG_PING_INTERVAL, '0);
        write_reg(uper_pkg::CFG_TRIGGER_WIDTH, 16'd5);
        set_idling(21, 21);
        feed_pulses(TOTAL_ITEMS - fed);
        drain();

        if (mismatches == 0 && reading_due.size() == 0)
            $display("tb_ultrasonic_ping_echo_ranger OK");
        else
            $display("tb_ultrasonic_ping_echo_ranger NOT OK");
        $finish;
    end
endmodule
